// ----- src/sud16_pkg.sv -----
`default_nettype none

package sud16_pkg;

   localparam int DVD_W   = 32;
   localparam int DVS_W   = 16;
   localparam int REG_W   = 3;
   localparam int DIV_W   = 4;
   localparam int CYC_W   = 8;
   localparam int COUNT_W = 12;
   localparam int STEPS   = 16;

   localparam logic CMD_DIVU = 1'b0;
   localparam logic CMD_DIVS = 1'b1;

   localparam logic [DIV_W-1:0] CLK_DIV_RESET = 4'd7;

   localparam logic [CYC_W-1:0] CYC_DIVU_BASE = 8'd12;
   localparam logic [CYC_W-1:0] CYC_DIVU_OVF  = 8'd6;
   localparam logic [CYC_W-1:0] CYC_DIVS_BASE = 8'd12;
   localparam logic [CYC_W-1:0] CYC_DVD_NEG   = 8'd2;
   localparam logic [CYC_W-1:0] CYC_TOP       = 8'd4;
   localparam logic [CYC_W-1:0] CYC_SUB       = 8'd6;
   localparam logic [CYC_W-1:0] CYC_SHIFT     = 8'd8;
   localparam logic [CYC_W-1:0] CYC_NEG_DVS   = 8'd16;
   localparam logic [CYC_W-1:0] CYC_NEG_DVD   = 8'd18;
   localparam logic [CYC_W-1:0] CYC_POS_POS   = 8'd14;

   typedef struct packed {
      logic             cmd;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
      logic [REG_W-1:0] target_reg;
   } req_type;

   typedef struct packed {
      logic [DVD_W-1:0]   packed_result;
      logic               write_enable;
      logic [REG_W-1:0]   target_reg_out;
      logic               n_flag;
      logic               z_flag;
      logic               v_flag;
      logic [COUNT_W-1:0] cycles_spent;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/signed_unsigned_divide_16.sv -----
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   sud16_pkg::req_type
// rsp      out        rsp_valid/rsp_stall   sud16_pkg::rsp_type
// csr      in         csr_valid/csr_ready   clock divider, 4 bits
//
// One transfer is taken every cycle while req_stall is low.
// The latency is set by the 16 shift-subtract stages, one quotient bit each,
// plus entry, overflow check, sign fixup and output stages.
// Reset is synchronous; it empties the pipeline and sets the clock divider to 7.
// A result held by rsp_stall freezes every stage and raises req_stall in that cycle.
`default_nettype none

module signed_unsigned_divide_16 (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire sud16_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sud16_pkg::rsp_type      rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [3:0]         csr_data
);

   import sud16_pkg::*;

   localparam int NUM_ST = STEPS + 2;

   typedef struct packed {
      logic             cmd;
      logic             ovf;
      logic             dvd_neg;
      logic             dvs_neg;
      logic [DVD_W-1:0] orig;
      logic [DVD_W-1:0] rem;
      logic [DVS_W-1:0] dsh_hi;
      logic [DVS_W-1:0] quo;
      logic [CYC_W-1:0] cyc;
      logic [REG_W-1:0] tgt;
   } stage_type;

   typedef struct packed {
      logic [DVD_W-1:0] res;
      logic             we;
      logic [REG_W-1:0] tgt;
      logic             n;
      logic             z;
      logic             v;
      logic [CYC_W-1:0] cyc;
   } fix_type;

   function automatic stage_type div_step(input stage_type s, input logic last);
      stage_type        r;
      logic             top;
      logic [DVD_W-1:0] sh;
      logic             ge;
      r   = s;
      top = s.rem[DVD_W-1];
      sh  = {s.rem[DVD_W-2:0], 1'b0};
      ge  = top || (sh[DVD_W-1:DVS_W] >= s.dsh_hi);
      r.rem = ge ? (sh - {s.dsh_hi, {DVS_W{1'b0}}}) : sh;
      r.quo = {s.quo[DVS_W-2:0], ge};
      if (!last && !s.ovf) begin
         r.cyc = s.cyc + (top ? CYC_TOP : (ge ? CYC_SUB : CYC_SHIFT));
      end
      return r;
   endfunction

   logic             adv;
   logic [DIV_W-1:0] clk_div_ff;
   stage_type        entry_in;
   stage_type        chk_in;
   stage_type        st_ff [NUM_ST];
   logic             vld_ff [NUM_ST];
   fix_type          fix_in, fix_ff;
   logic             fix_vld_ff;
   rsp_type          rsp_in, rsp_ff;
   logic             rsp_vld_ff;

   logic [DVS_W-1:0] qm, qn, rm, rn, qf, rf;
   logic             ovf_f;
   logic [CYC_W-1:0] cyc_f;

   assign adv       = !(rsp_vld_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_div_ff <= CLK_DIV_RESET;
      end else if (csr_valid && csr_ready) begin
         clk_div_ff <= csr_data;
      end
   end

   always_comb begin
      entry_in         = '0;
      entry_in.cmd     = req_data.cmd;
      entry_in.dvd_neg = (req_data.cmd == CMD_DIVS) && req_data.dividend[DVD_W-1];
      entry_in.dvs_neg = (req_data.cmd == CMD_DIVS) && req_data.divisor[DVS_W-1];
      entry_in.orig    = req_data.dividend;
      entry_in.rem     = entry_in.dvd_neg ? (-req_data.dividend) : req_data.dividend;
      entry_in.dsh_hi  = entry_in.dvs_neg ? (-req_data.divisor) : req_data.divisor;
      entry_in.tgt     = req_data.target_reg;
      if (req_data.cmd == CMD_DIVS) begin
         entry_in.cyc = entry_in.dvd_neg ? (CYC_DIVS_BASE + CYC_DVD_NEG) : CYC_DIVS_BASE;
      end else begin
         entry_in.cyc = CYC_DIVU_BASE;
      end
   end

   always_comb begin
      chk_in = st_ff[0];
      if (st_ff[0].cmd == CMD_DIVS) begin
         chk_in.ovf = ({st_ff[0].dsh_hi, {DVS_W{1'b0}}} <= st_ff[0].rem);
      end else begin
         chk_in.ovf = ({st_ff[0].dsh_hi, {DVS_W{1'b0}}} < st_ff[0].rem);
         if (chk_in.ovf) begin
            chk_in.cyc = CYC_DIVU_OVF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
         vld_ff[1] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         vld_ff[1] <= vld_ff[0];
      end
      if (adv) begin
         st_ff[0] <= entry_in;
         st_ff[1] <= chk_in;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+2] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+2] <= vld_ff[k+1];
         end
         if (adv) begin
            st_ff[k+2] <= div_step(st_ff[k+1], k == STEPS - 1);
         end
      end
   end

   always_comb begin
      qm    = st_ff[NUM_ST-1].quo;
      rm    = st_ff[NUM_ST-1].rem[DVD_W-1:DVS_W];
      qn    = -qm;
      rn    = -rm;
      qf    = qm;
      rf    = rm;
      ovf_f = st_ff[NUM_ST-1].ovf;
      cyc_f = st_ff[NUM_ST-1].cyc;
      if (!st_ff[NUM_ST-1].ovf && st_ff[NUM_ST-1].cmd == CMD_DIVS) begin
         if (st_ff[NUM_ST-1].dvs_neg) begin
            cyc_f = cyc_f + CYC_NEG_DVS;
            if (st_ff[NUM_ST-1].dvd_neg) begin
               if (qm[DVS_W-1]) begin
                  ovf_f = 1'b1;
               end else begin
                  rf = rn;
               end
            end else begin
               qf = qn;
               if (qn != '0 && !qn[DVS_W-1]) begin
                  ovf_f = 1'b1;
               end
            end
         end else if (st_ff[NUM_ST-1].dvd_neg) begin
            cyc_f = cyc_f + CYC_NEG_DVD;
            qf    = qn;
            if (qn != '0 && !qn[DVS_W-1]) begin
               ovf_f = 1'b1;
            end else begin
               rf = rn;
            end
         end else begin
            cyc_f = cyc_f + CYC_POS_POS;
            if (qm[DVS_W-1]) begin
               ovf_f = 1'b1;
            end
         end
      end
      fix_in.tgt = st_ff[NUM_ST-1].tgt;
      fix_in.cyc = cyc_f;
      if (ovf_f) begin
         fix_in.res = st_ff[NUM_ST-1].orig;
         fix_in.we  = 1'b0;
         fix_in.n   = 1'b1;
         fix_in.z   = 1'b0;
         fix_in.v   = 1'b1;
      end else begin
         fix_in.res = {rf, qf};
         fix_in.we  = 1'b1;
         fix_in.n   = qf[DVS_W-1];
         fix_in.z   = (qf == '0);
         fix_in.v   = 1'b0;
      end
   end

   always_comb begin
      rsp_in.packed_result  = fix_ff.res;
      rsp_in.write_enable   = fix_ff.we;
      rsp_in.target_reg_out = fix_ff.tgt;
      rsp_in.n_flag         = fix_ff.n;
      rsp_in.z_flag         = fix_ff.z;
      rsp_in.v_flag         = fix_ff.v;
      rsp_in.cycles_spent   = {{(COUNT_W-CYC_W){1'b0}}, fix_ff.cyc}
                            * {{(COUNT_W-DIV_W){1'b0}}, clk_div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         fix_vld_ff <= vld_ff[NUM_ST-1];
         rsp_vld_ff <= fix_vld_ff;
      end
      if (adv) begin
         fix_ff <= fix_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/sud16_checker.sv -----
`default_nettype none

module sud16_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire sud16_pkg::req_type req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire sud16_pkg::rsp_type rsp_data
);

   import sud16_pkg::*;

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // A stalled request holds its transfer unchanged.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // A stalled result holds its transfer unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // The input side only waits while the output side holds a result back.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without an output stall");

   // Overflow suppresses the register write and forces N set and Z clear.
   a_ovf_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.v_flag == !rsp_data.write_enable)
                    && (!rsp_data.v_flag || (rsp_data.n_flag && !rsp_data.z_flag)))
      else $error("overflow flags inconsistent");

endmodule

bind signed_unsigned_divide_16 sud16_checker u_sud16_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import sud16_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 25;
   localparam int HOLD_CYCLES    = 200;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_valid  = 1'b0;
   logic        req_stall;
   req_type     req_data   = '0;
   logic        rsp_valid;
   logic        rsp_stall  = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data   = CLK_DIV_RESET;

   logic [3:0]  divider_copy = CLK_DIV_RESET;
   rsp_type     expected_divides[$];
   int          fail_count   = 0;
   int          sender_idle_pct = 0;
   int          stall_pct       = 0;
   int          hold_request    = 0;

   signed_unsigned_divide_16 u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type predict_divide(input req_type item, input logic [3:0] divider);
      rsp_type     r;
      logic [31:0] acc;
      logic [31:0] dsh;
      logic [31:0] orig_dsh;
      logic [31:0] orig_dvd;
      logic [31:0] scaled;
      logic [15:0] quo;
      logic        bit_in;
      logic        top;
      logic        ovf;
      logic        done;
      int unsigned cyc;
      r.target_reg_out = item.target_reg;
      r.packed_result  = item.dividend;
      r.write_enable   = 1'b0;
      r.n_flag         = 1'b1;
      r.z_flag         = 1'b0;
      r.v_flag         = 1'b1;
      acc    = item.dividend;
      dsh    = {item.divisor, 16'h0000};
      quo    = '0;
      bit_in = 1'b0;
      top    = 1'b0;
      ovf    = 1'b0;
      done   = 1'b0;
      if (item.cmd == CMD_DIVU) begin
         if (dsh < acc) begin
            cyc = 6;
         end else begin
            cyc = 2;
            for (int i = 0; i < 16; i++) begin
               top = acc[31];
               quo = {quo[14:0], bit_in};
               acc = acc << 1;
               if (top || acc >= dsh) begin
                  acc    = acc - dsh;
                  cyc    = cyc + (top ? 4 : 6);
                  bit_in = 1'b1;
               end else begin
                  bit_in = 1'b0;
                  cyc    = cyc + 8;
               end
            end
            cyc = cyc + (top ? 6 : (bit_in ? 4 : 2));
            quo = {quo[14:0], bit_in};
            r.packed_result = acc | {16'h0000, quo};
            r.write_enable  = 1'b1;
            r.v_flag        = 1'b0;
            r.n_flag        = quo[15];
            r.z_flag        = (quo == 16'h0000);
         end
      end else begin
         cyc      = 8;
         orig_dsh = dsh;
         orig_dvd = acc;
         if (dsh[31]) dsh = -dsh;
         if (acc[31]) begin
            acc = -acc;
            cyc = cyc + 2;
         end
         if (dsh <= acc) begin
            cyc  = cyc + 4;
            done = 1'b1;
         end else begin
            for (int i = 0; i < 15; i++) begin
               quo = {quo[14:0], bit_in};
               acc = acc << 1;
               if (acc >= dsh) begin
                  acc    = acc - dsh;
                  cyc    = cyc + 6;
                  bit_in = 1'b1;
               end else begin
                  bit_in = 1'b0;
                  cyc    = cyc + 8;
               end
            end
            quo = {quo[14:0], bit_in};
            acc = acc << 1;
            if (acc >= dsh) begin
               acc = acc - dsh;
               quo = {quo[14:0], 1'b1};
            end else begin
               quo = {quo[14:0], 1'b0};
            end
            cyc = cyc + 4;
            if (orig_dsh[31]) begin
               cyc = cyc + 16;
               if (orig_dvd[31]) begin
                  if (quo[15]) done = 1'b1;
                  else acc = -acc;
               end else begin
                  quo = -quo;
                  if (quo != 16'h0000 && !quo[15]) ovf = 1'b1;
               end
            end else if (orig_dvd[31]) begin
               cyc = cyc + 18;
               quo = -quo;
               if (quo != 16'h0000 && !quo[15]) ovf = 1'b1;
               else acc = -acc;
            end else begin
               cyc = cyc + 14;
               if (quo[15]) ovf = 1'b1;
            end
            if (!done && !ovf) begin
               r.packed_result = {acc[31:16], quo};
               r.write_enable  = 1'b1;
               r.v_flag        = 1'b0;
               r.n_flag        = quo[15];
               r.z_flag        = (quo == 16'h0000);
            end
         end
      end
      scaled = cyc * divider;
      r.cycles_spent = scaled[COUNT_W-1:0];
      return r;
   endfunction

   function automatic req_type make_req(input logic cmd, input logic [31:0] dividend,
                                        input logic [15:0] divisor, input logic [2:0] target);
      req_type item;
      item.cmd        = cmd;
      item.dividend   = dividend;
      item.divisor    = divisor;
      item.target_reg = target;
      return item;
   endfunction

   // Most items are built from a quotient, a divisor and a remainder so that
   // the full shift-subtract path is exercised; the rest are raw noise.
   function automatic req_type random_divide();
      req_type     item;
      int unsigned shape;
      int unsigned dvs_mag;
      int unsigned quo_mag;
      int unsigned rem_mag;
      int unsigned mag;
      item.cmd        = ($urandom_range(1, 0) == 1) ? CMD_DIVS : CMD_DIVU;
      item.target_reg = REG_W'($urandom_range(7, 0));
      shape = $urandom_range(9, 0);
      case (shape)
         0: item.divisor = '0;
         1: item.divisor = '1;
         2: item.divisor = 16'h0001;
         3: item.divisor = 16'h8000;
         default: item.divisor = DVS_W'($urandom);
      endcase
      if (shape >= 7) begin
         item.dividend = $urandom;
      end else begin
         if (item.cmd == CMD_DIVS && item.divisor[15]) dvs_mag = 32'h10000 - item.divisor;
         else dvs_mag = 32'(item.divisor);
         if (item.cmd == CMD_DIVS) quo_mag = $urandom_range(32'h8000, 0);
         else quo_mag = $urandom_range(32'hFFFF, 0);
         quo_mag = quo_mag >> $urandom_range(15, 0);
         rem_mag = (dvs_mag == 0) ? 0 : $urandom % dvs_mag;
         mag = quo_mag * dvs_mag + rem_mag;
         if (item.cmd == CMD_DIVS && $urandom_range(1, 0) == 1) item.dividend = -mag;
         else item.dividend = mag;
      end
      return item;
   endfunction

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= 10) $display("%s", what);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) note_failure($sformatf("%s mismatch: expected %h, actual %h",
                                               name, want, got));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         divider_copy <= CLK_DIV_RESET;
      end else begin
         if (csr_valid && csr_ready === 1'b1) divider_copy <= csr_data;
         if (req_valid && req_stall === 1'b0)
            expected_divides.push_back(predict_divide(req_data, divider_copy));
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_divides.size() == 0) begin
            note_failure($sformatf("unexpected result %h", rsp_data));
         end else begin
            want = expected_divides.pop_front();
            check_field("packed_result", want.packed_result, rsp_data.packed_result);
            check_field("write_enable", 32'(want.write_enable),
                        32'(rsp_data.write_enable));
            check_field("target_reg_out", 32'(want.target_reg_out),
                        32'(rsp_data.target_reg_out));
            check_field("n_flag", 32'(want.n_flag), 32'(rsp_data.n_flag));
            check_field("z_flag", 32'(want.z_flag), 32'(rsp_data.z_flag));
            check_field("v_flag", 32'(want.v_flag), 32'(rsp_data.v_flag));
            check_field("cycles_spent", 32'(want.cycles_spent),
                        32'(rsp_data.cycles_spent));
         end
      end
   end

   // A hold request keeps the result side stalled for that many cycles.
   always @(posedge clock) begin : drive_rsp_stall
      int hold_left;
      if (hold_left == 0 && hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
             (csr_valid && csr_ready === 1'b1)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("signed_unsigned_divide_16 verification failed");
      $finish;
   end

   task automatic send_divide(input req_type item);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_divides.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_clock_divider(input logic [3:0] value);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed();
      sender_idle_pct = 0;
      stall_pct       = 0;
      send_divide(make_req(CMD_DIVU, 32'h0000_0000, 16'h0000, 3'd0));
      send_divide(make_req(CMD_DIVU, 32'h0000_0005, 16'h0000, 3'd7));
      send_divide(make_req(CMD_DIVU, 32'hFFFF_FFFF, 16'hFFFF, 3'd1));
      send_divide(make_req(CMD_DIVU, 32'hFFFE_FFFF, 16'hFFFF, 3'd2));
      send_divide(make_req(CMD_DIVU, 32'hFFFF_0000, 16'hFFFF, 3'd3));
      send_divide(make_req(CMD_DIVU, 32'h0000_0064, 16'h0007, 3'd4));
      send_divide(make_req(CMD_DIVU, 32'h0000_0001, 16'hFFFF, 3'd5));
      send_divide(make_req(CMD_DIVU, 32'hFFFF_FFFF, 16'h0001, 3'd6));
      send_divide(make_req(CMD_DIVU, 32'h0000_FFFF, 16'h0001, 3'd7));
      send_divide(make_req(CMD_DIVU, 32'h8000_0000, 16'h8000, 3'd0));
      send_divide(make_req(CMD_DIVS, 32'h0000_0000, 16'h0000, 3'd1));
      send_divide(make_req(CMD_DIVS, 32'h0001_2345, 16'h0000, 3'd2));
      send_divide(make_req(CMD_DIVS, 32'hFFFF_FFF9, 16'h0002, 3'd3));
      send_divide(make_req(CMD_DIVS, 32'h0000_0007, 16'hFFFE, 3'd4));
      send_divide(make_req(CMD_DIVS, 32'hFFFF_FFF9, 16'hFFFE, 3'd5));
      send_divide(make_req(CMD_DIVS, 32'h8000_0000, 16'hFFFF, 3'd6));
      send_divide(make_req(CMD_DIVS, 32'h7FFF_FFFF, 16'h0001, 3'd7));
      send_divide(make_req(CMD_DIVS, 32'h0000_7FFF, 16'h0001, 3'd0));
      send_divide(make_req(CMD_DIVS, 32'hFFFF_8000, 16'h0001, 3'd1));
      send_divide(make_req(CMD_DIVS, 32'h0000_8000, 16'h0001, 3'd2));
      send_divide(make_req(CMD_DIVS, 32'hFFFF_8000, 16'hFFFF, 3'd3));
      send_divide(make_req(CMD_DIVS, 32'h0000_8000, 16'hFFFF, 3'd4));
      send_divide(make_req(CMD_DIVS, 32'hFFFF_FFFF, 16'h0001, 3'd5));
      send_divide(make_req(CMD_DIVS, 32'h3FFF_8000, 16'h8000, 3'd6));
      send_divide(make_req(CMD_DIVS, 32'h8000_0000, 16'h8000, 3'd7));
      wait_until_drained();
   endtask

   task automatic test_divider_extremes();
      logic [3:0] settings[3];
      settings = '{4'd1, 4'd15, 4'd0};
      sender_idle_pct = 0;
      stall_pct       = 0;
      foreach (settings[s]) begin
         write_clock_divider(settings[s]);
         repeat (20) send_divide(random_divide());
      end
      wait_until_drained();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_percent,
                                      input int count);
      write_clock_divider(4'($urandom_range(15, 1)));
      sender_idle_pct = idle_pct;
      stall_pct       = stall_percent;
      repeat (count) send_divide(random_divide());
      wait_until_drained();
   endtask

   // The result side holds off long enough for the pipeline to fill, so the
   // input must stall while the sender keeps a transfer on offer.
   task automatic test_backpressure();
      write_clock_divider(4'd7);
      sender_idle_pct = 0;
      stall_pct       = 0;
      hold_request    = HOLD_CYCLES;
      repeat (100) send_divide(random_divide());
      wait_until_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_divider_extremes();
      test_random_traffic(0, 0, 260);
      test_random_traffic(65, 0, 260);
      test_random_traffic(0, 65, 260);
      test_random_traffic(32, 32, 260);
      test_backpressure();
      if (expected_divides.size() != 0)
         note_failure($sformatf("%0d results never arrived", expected_divides.size()));
      if (fail_count == 0) begin
         $display("signed_unsigned_divide_16 verification clean");
      end else begin
         $display("signed_unsigned_divide_16 verification failed");
      end
      $finish;
   end

endmodule
